/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define BNSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// same, with a message of its own
`define BNSQ_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

/* hdl/bnsq_pkg.sv */
// types and constants of the batch numbered shift queue
package bnsq_pkg;

    localparam int QDEPTH = 16;
    localparam int IDX_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);
    localparam int OP_W   = 2;
    localparam int AMT_W  = 8;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 5;
    localparam int CMP_W  = ((AMT_W > CNT_W) ? AMT_W : CNT_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DUMP = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } t_state;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_PUSH,
        CM_SHIFT,
        CM_ROTATE,
        CM_CLEAR
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode       mode;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] new_count;
        logic [VAL_W-1:0] base;
    } t_cell_ctl;

    typedef struct packed {
        t_status          status;
        logic [OCC_W-1:0] occupancy;
        logic [VAL_W-1:0] entry_value;
        logic             entry_valid;
        logic             last;
    } t_out_word;

endpackage

/* hdl/bnsq_in_if.sv */
// input channel: operation words
interface bnsq_in_if;
    import bnsq_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [AMT_W-1:0] amount;

    modport source (output valid, output op, output amount, input ready);
    modport sink (input valid, input op, input amount, output ready);
endinterface

/* hdl/bnsq_out_if.sv */
// output channel: result words
interface bnsq_out_if;
    import bnsq_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
    logic [VAL_W-1:0] entry_value;
    logic             entry_valid;
    logic             last;

    modport source (
        output valid, output status, output occupancy, output entry_value,
        output entry_valid, output last, input ready
    );
    modport sink (
        input valid, input status, input occupancy, input entry_value,
        input entry_valid, input last, output ready
    );
endinterface

/* hdl/bnsq_cell.sv */
// one slot of the queue: holds a ticket and trades it with its neighbor
module bnsq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bnsq_pkg::IDX_W-1:0] i_idx,
    input  bnsq_pkg::t_cell_ctl        i_ctl,
    input  logic [bnsq_pkg::VAL_W-1:0] i_next,
    input  logic [bnsq_pkg::VAL_W-1:0] i_head,
    output logic [bnsq_pkg::VAL_W-1:0] o_val
);
    import bnsq_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic [CNT_W-1:0] idx_x;
    logic [CNT_W-1:0] offs;

    assign idx_x = CNT_W'(i_idx);
    assign offs  = idx_x - i_ctl.count;

    always_comb begin
        n_val = r_val;
        case (i_ctl.mode)
            CM_PUSH: begin
                // slots between old and new tail get the next tickets
                if (idx_x >= i_ctl.count && idx_x < i_ctl.new_count) begin
                    n_val = i_ctl.base + VAL_W'(offs) + VAL_W'(1);
                end
            end
            CM_SHIFT: n_val = i_next;
            CM_ROTATE: begin
                // tail slot takes the head so the contents come back in order
                if (idx_x == i_ctl.count - CNT_W'(1)) begin
                    n_val = i_head;
                end else begin
                    n_val = i_next;
                end
            end
            CM_CLEAR: n_val = '0;
            default:  n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
endmodule

/* hdl/batch_numbered_shift_queue.sv */
// top level: shift-register queue of ticket numbers
//
// Channels: i_in takes one word per operation (op, amount); o_out returns
// result words (status, occupancy, entry_value, entry_valid, last). Both use
// valid/ready; a word moves on a rising edge with valid and ready high.
// Push, pop and any unknown op give one result word, registered in the
// cycle of acceptance and shown on o_out the cycle after.
// Push writes all new tickets together: every cell computes its own
// ticket. Pop moves the row of cells one place toward the head per cycle,
// amount times; a pop past the occupancy clears all cells at once.
// Dump sends one word per cycle from the head cell while o_out does not
// stall, and the row rotates with each word, so the contents are
// unchanged afterward. An empty dump gives a single word.
// One operation is in flight at a time; i_in.ready is high when the
// sequencer is idle and the output register is free or being emptied.
// A stall on o_out holds the output register and halts a dump in place.
// Reset (i_rst_n low at a clock edge) empties the queue, zeroes all cells
// and the ticket counter, and drops o_out.valid.
module batch_numbered_shift_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bnsq_in_if.sink           i_in,
    bnsq_out_if.source        o_out
);
    import bnsq_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] n_rem;
    logic [VAL_W-1:0] r_ticket;
    logic [VAL_W-1:0] n_ticket;
    logic             r_ov;
    logic             n_ov;
    t_out_word        r_out;
    t_out_word        n_out;
    t_cell_ctl        cell_ctl;

    logic [VAL_W-1:0] w_slot [QDEPTH];
    logic [VAL_W-1:0] w_next [QDEPTH];

    logic             out_free;
    logic             in_acc;
    logic [CNT_W-1:0] free_slots;
    logic [CMP_W-1:0] amt_x;
    logic             push_ovf;
    logic             pop_unf;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] push_cnt;
    logic [CNT_W-1:0] pop_cnt;

    assign out_free   = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in.valid && i_in.ready;

    assign free_slots = CNT_W'(QDEPTH) - r_count;
    assign amt_x      = CMP_W'(i_in.amount);
    assign push_ovf   = amt_x > CMP_W'(free_slots);
    assign pop_unf    = amt_x > CMP_W'(r_count);
    assign fill       = push_ovf ? free_slots : CNT_W'(i_in.amount);
    assign push_cnt   = r_count + fill;
    assign pop_cnt    = r_count - CNT_W'(i_in.amount);

    always_comb begin
        n_state            = r_state;
        n_count            = r_count;
        n_rem              = r_rem;
        n_ticket           = r_ticket;
        n_ov               = r_ov && !o_out.ready;
        n_out              = r_out;
        cell_ctl.mode      = CM_HOLD;
        cell_ctl.count     = r_count;
        cell_ctl.new_count = r_count;
        cell_ctl.base      = r_ticket;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ov              = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.occupancy   = OCC_W'(r_count);
                    n_out.entry_value = '0;
                    n_out.entry_valid = 1'b0;
                    n_out.last        = 1'b1;
                    case (i_in.op)
                        OP_PUSH: begin
                            cell_ctl.mode      = CM_PUSH;
                            cell_ctl.new_count = push_cnt;
                            n_count            = push_cnt;
                            n_ticket           = r_ticket + VAL_W'(i_in.amount);
                            n_out.status       = push_ovf ? ST_OVERFLOW : ST_OK;
                            n_out.occupancy    = OCC_W'(push_cnt);
                        end
                        OP_POP: begin
                            if (pop_unf) begin
                                cell_ctl.mode   = CM_CLEAR;
                                n_count         = '0;
                                n_out.status    = ST_UNDERFLOW;
                                n_out.occupancy = '0;
                            end else begin
                                n_count         = pop_cnt;
                                n_out.occupancy = OCC_W'(pop_cnt);
                                if (i_in.amount != '0) begin
                                    n_rem   = CNT_W'(i_in.amount);
                                    n_state = S_POP;
                                end
                            end
                        end
                        OP_DUMP: begin
                            // words leave one per cycle from the dump state while o_out is not stalled
                            if (r_count != '0) begin
                                n_ov    = 1'b0;
                                n_rem   = r_count;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                cell_ctl.mode = CM_SHIFT;
                n_rem         = r_rem - CNT_W'(1);
                if (r_rem == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    cell_ctl.mode     = CM_ROTATE;
                    n_ov              = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.occupancy   = OCC_W'(r_count);
                    n_out.entry_value = w_slot[0];
                    n_out.entry_valid = 1'b1;
                    n_out.last        = (r_rem == CNT_W'(1));
                    n_rem             = r_rem - CNT_W'(1);
                    if (r_rem == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rem    <= '0;
            r_ticket <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rem    <= n_rem;
            r_ticket <= n_ticket;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    for (genvar g = 0; g < QDEPTH; g++) begin : g_cell
        if (g == QDEPTH - 1) begin : g_tail
            assign w_next[g] = '0;
        end else begin : g_mid
            assign w_next[g] = w_slot[g+1];
        end

        bnsq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (cell_ctl),
            .i_next  (w_next[g]),
            .i_head  (w_slot[0]),
            .o_val   (w_slot[g])
        );
    end

    assign o_out.valid       = r_ov;
    assign o_out.status      = r_out.status;
    assign o_out.occupancy   = r_out.occupancy;
    assign o_out.entry_value = r_out.entry_value;
    assign o_out.entry_valid = r_out.entry_valid;
    assign o_out.last        = r_out.last;
endmodule

/* hdl/bnsq_checker.sv */
// port-level checks of the queue, bound to the top level
`include "assert_macros.svh"

module bnsq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [bnsq_pkg::ST_W-1:0]  i_status,
    input logic [bnsq_pkg::OCC_W-1:0] i_occupancy,
    input logic [bnsq_pkg::VAL_W-1:0] i_entry_value,
    input logic                       i_entry_valid,
    input logic                       i_last
);
    import bnsq_pkg::*;

    // a stalled result word stays offered
    `BNSQ_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // dump words carry ok status and a nonempty queue
    `BNSQ_ASSERT_MSG(a_dump_ok, i_clk, i_rst_n, i_out_valid && i_entry_valid |-> i_status == ST_OK && i_occupancy != '0, "dump word with bad status or occupancy")

    // words without an entry carry a zero value and end their operation
    `BNSQ_ASSERT_MSG(a_no_entry, i_clk, i_rst_n, i_out_valid && !i_entry_valid |-> i_entry_value == '0 && i_last, "result word not cleared or not last")

    // no new operation is taken in the middle of a dump
    `BNSQ_ASSERT_MSG(a_dump_busy, i_clk, i_rst_n, i_out_valid && i_entry_valid && !i_last |-> !(i_in_valid && i_in_ready), "operation taken during dump")

    // occupancy never exceeds the queue depth
    `BNSQ_ASSERT(a_occ_range, i_clk, i_rst_n, i_out_valid |-> i_occupancy <= QDEPTH)
endmodule

bind batch_numbered_shift_queue bnsq_checker u_bnsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_occupancy   (o_out.occupancy),
    .i_entry_value (o_out.entry_value),
    .i_entry_valid (o_out.entry_valid),
    .i_last        (o_out.last)
);
